### hdl/knn_idw_pkg.sv
// shared constants, types and codes for the k-nearest inverse-distance weighting block
`default_nettype none
package knn_idw_pkg;

  localparam int MAX_POINTS = 64;
  localparam int NEAREST    = 4;
  localparam int IDX_W      = 6;
  localparam int CNT_W      = 7;
  localparam int SLOT_W     = 2;
  localparam int USED_W     = 3;
  localparam int COORD_W    = 13;
  localparam int PIX_W      = 12;
  localparam int D2_W       = 27;
  localparam int R_W        = 37;
  localparam int SUM_W      = 39;
  localparam int REM_W      = 40;
  localparam int DVSR_W     = 39;
  localparam int Q_W        = 40;
  localparam int WT_W       = 16;
  localparam int STEP_W     = 6;
  localparam int R_STEPS    = 40;
  localparam int W_STEPS    = 16;
  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 24;

  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam logic [D2_W-1:0] R_BIAS  = D2_W'(16);
  localparam logic [WT_W-1:0] WT_SAT  = {WT_W{1'b1}};

  typedef struct packed {
    logic               kind;
    logic [IDX_W-1:0]   point_index;
    logic [COORD_W-1:0] point_x;
    logic [COORD_W-1:0] point_y;
    logic [PIX_W-1:0]   pixel_x;
    logic [PIX_W-1:0]   pixel_y;
  } item_t;

  typedef struct packed {
    logic              start;
    logic [REM_W-1:0]  rem0;
    logic [DVSR_W-1:0] dvsr;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic           busy;
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage
`default_nettype wire

### hdl/knn_idw_front.sv
// input side: takes words, unpacks them and holds them in a two-entry queue
`default_nettype none
module knn_idw_front (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [knn_idw_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic                                 in_tuser,
  output logic                                      q_valid,
  output knn_idw_pkg::item_t                        q_item,
  input  wire logic                                 q_ready
);

  knn_idw_pkg::item_t ent_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;
  knn_idw_pkg::item_t in_item;

  always_comb begin
    in_item.kind        = in_tuser;
    in_item.point_index = in_tdata[5:0];
    in_item.point_x     = in_tdata[18:6];
    in_item.point_y     = in_tdata[31:19];
    in_item.pixel_x     = in_tdata[43:32];
    in_item.pixel_y     = in_tdata[55:44];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign q_valid   = (cnt_r != 2'd0);
  assign pop       = q_valid && q_ready;
  assign q_item    = ent_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

### hdl/knn_idw_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module knn_idw_div (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire knn_idw_pkg::div_req_t req,
  output knn_idw_pkg::div_rsp_t    rsp
);

  logic [knn_idw_pkg::REM_W-1:0]  rem_r, rem_nxt;
  logic [knn_idw_pkg::DVSR_W-1:0] dvsr_r, dvsr_nxt;
  logic [knn_idw_pkg::Q_W-1:0]    quot_r, quot_nxt;
  logic [knn_idw_pkg::STEP_W-1:0] left_r, left_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [knn_idw_pkg::REM_W:0]    rem2;
  logic                           ge;

  always_comb begin
    rem2     = {rem_r, 1'b0};
    ge       = (rem2 >= {2'b00, dvsr_r});
    rem_nxt  = rem_r;
    dvsr_nxt = dvsr_r;
    quot_nxt = quot_r;
    left_nxt = left_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.rem0;
      dvsr_nxt = req.dvsr;
      quot_nxt = '0;
      left_nxt = req.steps;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (ge) begin
        rem_nxt = knn_idw_pkg::REM_W'(rem2 - {2'b00, dvsr_r});
      end else begin
        rem_nxt = rem2[knn_idw_pkg::REM_W-1:0];
      end
      quot_nxt = {quot_r[knn_idw_pkg::Q_W-2:0], ge};
      left_nxt = left_r - 1'b1;
      if (left_r == knn_idw_pkg::STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      left_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dvsr_r <= dvsr_nxt;
    quot_r <= quot_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot_r;

endmodule
`default_nettype wire

### hdl/knn_idw_back.sv
// work side: point table, nearest search, weight divisions and result register
`default_nettype none
module knn_idw_back (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic [knn_idw_pkg::CNT_W-1:0]         point_count,
  input  wire logic                                  q_valid,
  input  wire knn_idw_pkg::item_t                    q_item,
  output logic                                       q_ready,
  output knn_idw_pkg::div_req_t                      div_req,
  input  wire knn_idw_pkg::div_rsp_t                 div_rsp,
  output logic                                       out_tvalid,
  input  wire logic                                  out_tready,
  output logic [knn_idw_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic                                       out_tlast
);

  localparam int N = knn_idw_pkg::NEAREST;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SCAN = 5'b00010,
    ST_RDIV = 5'b00100,
    ST_WDIV = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [2*knn_idw_pkg::COORD_W-1:0] mem [knn_idw_pkg::MAX_POINTS];
  logic [2*knn_idw_pkg::COORD_W-1:0] rd_data_r;
  logic                              mem_we;

  logic [knn_idw_pkg::CNT_W-1:0]   n_r, n_nxt;
  logic [knn_idw_pkg::CNT_W-1:0]   rd_cnt_r, rd_cnt_nxt;
  logic [knn_idw_pkg::COORD_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic                            issue;

  logic                          s1_v_r;
  logic [knn_idw_pkg::IDX_W-1:0] s1_idx_r;
  logic                          s2_v_r;
  logic [knn_idw_pkg::IDX_W-1:0] s2_idx_r;
  logic [knn_idw_pkg::D2_W-1:0]  s2_d_r;
  logic [knn_idw_pkg::COORD_W-1:0] dx, dy, px, py;
  logic [knn_idw_pkg::D2_W-1:0]  d2;

  logic [knn_idw_pkg::D2_W-1:0]  lst_d_r [N];
  logic [knn_idw_pkg::IDX_W-1:0] lst_i_r [N];
  logic [N-1:0]                  lst_v_r;
  logic [knn_idw_pkg::USED_W-1:0] pos, used;

  logic [knn_idw_pkg::R_W-1:0]   r_r [N];
  logic [knn_idw_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [knn_idw_pkg::SLOT_W-1:0] k_r, k_nxt;
  logic [knn_idw_pkg::USED_W-1:0] k_ext, k_inc;
  logic                          pend_r, pend_nxt;
  logic [knn_idw_pkg::WT_W-1:0]  w_r, w_nxt;
  logic                          r_we;
  logic                          out_load;
  logic [knn_idw_pkg::IDX_W-1:0] out_idx;

  assign k_ext = {1'b0, k_r};
  assign k_inc = k_ext + 1'b1;
  assign issue = (state_r == ST_SCAN) && (rd_cnt_r < n_r);
  assign q_ready = (state_r == ST_IDLE);
  assign mem_we  = q_valid && q_ready && (q_item.kind == knn_idw_pkg::KIND_LOAD);

  always_comb begin
    used = '0;
    for (int j = 0; j < N; j++) begin
      used = used + knn_idw_pkg::USED_W'(lst_v_r[j]);
    end
  end

  // insertion place: after every kept entry with distance not above the new one
  always_comb begin
    pos = '0;
    for (int j = 0; j < N; j++) begin
      if (lst_v_r[j] && (lst_d_r[j] <= s2_d_r)) begin
        pos = pos + 1'b1;
      end
    end
  end

  always_comb begin
    px = rd_data_r[knn_idw_pkg::COORD_W-1:0];
    py = rd_data_r[2*knn_idw_pkg::COORD_W-1:knn_idw_pkg::COORD_W];
    dx = (qx_r >= px) ? qx_r - px : px - qx_r;
    dy = (qy_r >= py) ? qy_r - py : py - qy_r;
    d2 = knn_idw_pkg::D2_W'(dx * dx) + knn_idw_pkg::D2_W'(dy * dy);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_item.point_index] <= {q_item.point_y, q_item.point_x};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_cnt_r[knn_idw_pkg::IDX_W-1:0]];
  end

  always_comb begin
    state_nxt  = state_r;
    n_nxt      = n_r;
    rd_cnt_nxt = rd_cnt_r;
    qx_nxt     = qx_r;
    qy_nxt     = qy_r;
    sum_nxt    = sum_r;
    k_nxt      = k_r;
    pend_nxt   = pend_r;
    w_nxt      = w_r;
    r_we       = 1'b0;
    out_load   = 1'b0;
    div_req    = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid && (q_item.kind == knn_idw_pkg::KIND_QUERY)) begin
          n_nxt      = (point_count > knn_idw_pkg::CNT_W'(knn_idw_pkg::MAX_POINTS)) ?
                       knn_idw_pkg::CNT_W'(knn_idw_pkg::MAX_POINTS) : point_count;
          rd_cnt_nxt = '0;
          qx_nxt     = {q_item.pixel_x, 1'b0};
          qy_nxt     = {q_item.pixel_y, 1'b0};
          sum_nxt    = '0;
          k_nxt      = '0;
          pend_nxt   = 1'b0;
          state_nxt  = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          rd_cnt_nxt = rd_cnt_r + 1'b1;
        end else if (!s1_v_r && !s2_v_r) begin
          state_nxt = (used == '0) ? ST_WDIV : ST_RDIV;
        end
      end
      ST_RDIV: begin
        if (!pend_r) begin
          div_req.start = 1'b1;
          div_req.rem0  = knn_idw_pkg::REM_W'(1);
          div_req.dvsr  = knn_idw_pkg::DVSR_W'(lst_d_r[k_r] + knn_idw_pkg::R_BIAS);
          div_req.steps = knn_idw_pkg::STEP_W'(knn_idw_pkg::R_STEPS);
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          r_we     = 1'b1;
          sum_nxt  = sum_r + knn_idw_pkg::SUM_W'(div_rsp.quot[knn_idw_pkg::R_W-1:0]);
          pend_nxt = 1'b0;
          if (k_inc == used) begin
            k_nxt     = '0;
            state_nxt = ST_WDIV;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end
      end
      ST_WDIV: begin
        if (k_ext >= used) begin
          w_nxt     = '0;
          state_nxt = ST_EMIT;
        end else if (knn_idw_pkg::SUM_W'(r_r[k_r]) == sum_r) begin
          w_nxt     = knn_idw_pkg::WT_SAT;
          state_nxt = ST_EMIT;
        end else if (!pend_r) begin
          div_req.start = 1'b1;
          div_req.rem0  = knn_idw_pkg::REM_W'(r_r[k_r]);
          div_req.dvsr  = knn_idw_pkg::DVSR_W'(sum_r);
          div_req.steps = knn_idw_pkg::STEP_W'(knn_idw_pkg::W_STEPS);
          pend_nxt      = 1'b1;
        end else if (div_rsp.done) begin
          w_nxt     = div_rsp.quot[knn_idw_pkg::WT_W-1:0];
          pend_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_tvalid || out_tready) begin
          out_load = 1'b1;
          if (k_inc == knn_idw_pkg::USED_W'(N)) begin
            state_nxt = ST_IDLE;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = ST_WDIV;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ranks without a point repeat the nearest index, or give index 0 when no point was found
  assign out_idx = (k_ext < used) ? lst_i_r[k_r] :
                   ((used != '0) ? lst_i_r[0] : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      lst_v_r    <= '0;
      pend_r     <= 1'b0;
      out_tvalid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= issue;
      s2_v_r  <= s1_v_r;
      pend_r  <= pend_nxt;
      if ((state_r == ST_IDLE) && (state_nxt == ST_SCAN)) begin
        lst_v_r <= '0;
      end else if (s2_v_r && (pos < knn_idw_pkg::USED_W'(N))) begin
        for (int j = 0; j < N; j++) begin
          if (knn_idw_pkg::USED_W'(j) == pos) begin
            lst_v_r[j] <= 1'b1;
          end else if (knn_idw_pkg::USED_W'(j) > pos) begin
            lst_v_r[j] <= lst_v_r[j-1];
          end
        end
      end
      if (out_load) begin
        out_tvalid <= 1'b1;
      end else if (out_tready) begin
        out_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r      <= n_nxt;
    rd_cnt_r <= rd_cnt_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    sum_r    <= sum_nxt;
    k_r      <= k_nxt;
    w_r      <= w_nxt;
    s1_idx_r <= rd_cnt_r[knn_idw_pkg::IDX_W-1:0];
    s2_idx_r <= s1_idx_r;
    s2_d_r   <= d2;
    if (r_we) begin
      r_r[k_r] <= div_rsp.quot[knn_idw_pkg::R_W-1:0];
    end
    if (s2_v_r && (pos < knn_idw_pkg::USED_W'(N))) begin
      for (int j = 0; j < N; j++) begin
        if (knn_idw_pkg::USED_W'(j) == pos) begin
          lst_d_r[j] <= s2_d_r;
          lst_i_r[j] <= s2_idx_r;
        end else if (knn_idw_pkg::USED_W'(j) > pos) begin
          lst_d_r[j] <= lst_d_r[j-1];
          lst_i_r[j] <= lst_i_r[j-1];
        end
      end
    end
    if (out_load) begin
      out_tdata <= {w_nxt, out_idx, k_r};
      out_tlast <= (k_inc == knn_idw_pkg::USED_W'(N));
    end
  end

endmodule
`default_nettype wire

### hdl/knn_inverse_distance_weights_core.sv
// top level of the k-nearest inverse-distance weighting block
//
//  channel   dir  handshake             payload
//  in_       in   in_tvalid/in_tready   in_tdata, in_tuser (kind)
//  out_      out  out_tvalid/out_tready out_tdata, out_tlast
//  cfg_      in   cfg_wr_en             cfg_wr_data (point_count)
//
// a load word passes through the queue into the point table; a query leaves the queue, then
// the table is scanned one entry per cycle through the table read port, then the shared
// divider computes a raw weight per found neighbour, then up to one normalizing division
// runs per rank. the two-entry input queue keeps taking words while a query runs, until it
// is full; the result register holds a word while out_tready is low.
// reset is synchronous and clears control only; the point table is not cleared.
`default_nettype none
module knn_inverse_distance_weights_core (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  // point_index, point_x, point_y, pixel_x, pixel_y
  input  wire logic [knn_idw_pkg::IN_DATA_W-1:0]   in_tdata,
  // kind
  input  wire logic                                in_tuser,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // slot, neighbour_index, weight
  output logic [knn_idw_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                     out_tlast,
  input  wire logic                                cfg_wr_en,
  input  wire logic [knn_idw_pkg::CNT_W-1:0]       cfg_wr_data
);

  logic [knn_idw_pkg::CNT_W-1:0] point_count_r;
  logic                          q_valid, q_ready;
  knn_idw_pkg::item_t            q_item;
  knn_idw_pkg::div_req_t         div_req;
  knn_idw_pkg::div_rsp_t         div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      point_count_r <= '0;
    end else if (cfg_wr_en) begin
      point_count_r <= cfg_wr_data;
    end
  end

  knn_idw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_ready   (q_ready)
  );

  knn_idw_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  knn_idw_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .point_count (point_count_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_ready     (q_ready),
    .div_req     (div_req),
    .div_rsp     (div_rsp),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast)
  );

endmodule
`default_nettype wire
